@@ rtl/hill_cipher_3x3_mod26_top_assert.svh @@
// ============================================================================
// hill_cipher_3x3_mod26_top_assert.svh
// Assertion macros for the Hill cipher block; empty under synthesis.
// ============================================================================
`ifndef HILL_CIPHER_3X3_MOD26_TOP_ASSERT_SVH
`define HILL_CIPHER_3X3_MOD26_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/hcm_pkg.sv @@
// ============================================================================
// hcm_pkg
// Shared types and constants of the 3x3 mod-26 Hill cipher.
// ============================================================================
package hcm_pkg;

    localparam int BLOCK_LEN  = 3;
    localparam int BYTE_W     = 8;
    localparam int KEY_W      = BLOCK_LEN * BYTE_W;
    localparam int CNT_W      = 2;
    localparam int HELD_IDX_W = $clog2(BLOCK_LEN - 1);
    localparam int PROD_W     = 2 * BYTE_W;
    // max column sum is 3 * 255 * 255 = 195075
    localparam int SUM_W      = 18;
    localparam int LETTER_W   = 7;
    localparam int RES_W      = 5;
    localparam int CFG_IDX_W  = 2;

    // x / 26 ~= (x * 10082) >> 18, low by at most one for x < 2^18
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 18;
    localparam int RPROD_W     = SUM_W + RECIP_W;
    localparam int Q_W         = 13;
    localparam logic [RECIP_W-1:0] RECIP = 14'd10082;

    localparam logic [SUM_W-1:0]    ALPHABET    = 18'd26;
    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd65;
    localparam logic [LETTER_W-1:0] LETTER_LAST = 7'd90;

    localparam logic [BLOCK_LEN-1:0][KEY_W-1:0] KEY_RESET =
        {24'h6D6168, 24'h61686F, 24'h686F4D};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROW_ZERO = 2'd0,
        CFG_KEY_ROW_ONE  = 2'd1,
        CFG_KEY_ROW_TWO  = 2'd2
    } t_cfg_idx;

    // block travelling down the cell row
    typedef struct packed {
        logic [BLOCK_LEN-1:0][BYTE_W-1:0] vec;      // remaining bytes, next at [0]
        logic [BLOCK_LEN-1:0][SUM_W-1:0]  sum;      // column sums so far
        logic [CNT_W-1:0]                 present;  // letters to emit
        logic                             last;     // message ends with this block
    } t_blk;

endpackage

@@ rtl/hcm_in_if.sv @@
// ============================================================================
// hcm_in_if
// Message byte channel: valid/ready with byte and end mark.
// ============================================================================
interface hcm_in_if;
    import hcm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] msg_byte;
    logic              msg_end;

    modport source (output valid, output msg_byte, output msg_end, input ready);
    modport sink   (input valid, input msg_byte, input msg_end, output ready);
endinterface

@@ rtl/hcm_out_if.sv @@
// ============================================================================
// hcm_out_if
// Cipher letter channel: valid/ready with ASCII letter and last mark.
// ============================================================================
interface hcm_out_if;
    import hcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] cipher_letter;
    logic                letter_last;

    modport source (output valid, output cipher_letter, output letter_last, input ready);
    modport sink   (input valid, input cipher_letter, input letter_last, output ready);
endinterface

@@ rtl/hcm_cell.sv @@
// ============================================================================
// hcm_cell
// One row of the key matrix: adds byte * key row to the column sums and
// hands the block, bytes shifted down, to the next cell.
// ============================================================================
module hcm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hcm_pkg::t_blk         i_blk,
    input  logic [hcm_pkg::KEY_W-1:0] i_key_row,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hcm_pkg::t_blk         o_blk
);
    import hcm_pkg::*;

    logic                             r_valid;
    t_blk                             r_blk;
    t_blk                             n_blk;
    logic [BLOCK_LEN-1:0][PROD_W-1:0] prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_blk   = r_blk;

    always_comb begin
        n_blk     = i_blk;
        n_blk.vec = i_blk.vec >> BYTE_W;
        for (int j = 0; j < BLOCK_LEN; j++) begin
            prod[j]      = i_blk.vec[0] * i_key_row[j*BYTE_W +: BYTE_W];
            n_blk.sum[j] = i_blk.sum[j] + SUM_W'(prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blk <= n_blk;
        end
    end

endmodule

@@ rtl/hcm_emit.sv @@
// ============================================================================
// hcm_emit
// Reduces the column sums mod 26 in two steps and sends the block's
// letters out one item per cycle while o_letter.ready is high.
// ============================================================================
module hcm_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hcm_pkg::t_blk i_blk,
    hcm_out_if.source     o_letter
);
    import hcm_pkg::*;

    // quotient stage
    logic                               r_q_valid;
    logic [BLOCK_LEN-1:0][SUM_W-1:0]    r_x;
    logic [BLOCK_LEN-1:0][Q_W-1:0]      r_q;
    logic [CNT_W-1:0]                   r_present;
    logic                               r_last;
    logic [BLOCK_LEN-1:0][RPROD_W-1:0]  rprod;

    // letter shifter
    logic                               r_s_valid;
    logic [BLOCK_LEN-1:0][LETTER_W-1:0] r_let;
    logic [BLOCK_LEN-1:0][LETTER_W-1:0] n_let;
    logic [CNT_W-1:0]                   r_left;
    logic                               r_s_last;
    logic [BLOCK_LEN-1:0][SUM_W-1:0]    rem;
    logic                               s_free;

    assign s_free  = !r_s_valid || (o_letter.ready && (r_left == CNT_W'(1)));
    assign o_ready = !r_q_valid || s_free;

    assign o_letter.valid         = r_s_valid;
    assign o_letter.cipher_letter = r_let[0];
    assign o_letter.letter_last   = r_s_last && (r_left == CNT_W'(1));

    always_comb begin
        for (int j = 0; j < BLOCK_LEN; j++) begin
            rprod[j] = RPROD_W'(i_blk.sum[j]) * RPROD_W'(RECIP);
            // estimate is exact or one short, so one correction
            rem[j]   = r_x[j] - SUM_W'(SUM_W'(r_q[j]) * ALPHABET);
            if (rem[j] >= ALPHABET) begin
                rem[j] = rem[j] - ALPHABET;
            end
            n_let[j] = LETTER_BASE + LETTER_W'(rem[j][RES_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_left    <= '0;
        end else begin
            if (o_ready) begin
                r_q_valid <= i_valid;
            end
            if (s_free) begin
                r_s_valid <= r_q_valid;
                r_left    <= r_present;
            end else if (o_letter.ready) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int j = 0; j < BLOCK_LEN; j++) begin
                r_x[j] <= i_blk.sum[j];
                r_q[j] <= rprod[j][RECIP_SHIFT +: Q_W];
            end
            r_present <= i_blk.present;
            r_last    <= i_blk.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_free && r_q_valid) begin
            r_let    <= n_let;
            r_s_last <= r_last;
        end else if (r_s_valid && o_letter.ready) begin
            r_let <= r_let >> LETTER_W;
        end
    end

endmodule

@@ rtl/hill_cipher_3x3_mod26_top.sv @@
// ============================================================================
// hill_cipher_3x3_mod26_top
// 3x3 Hill cipher mod 26 on a byte stream: bytes gather into blocks of
// three, a row of cells multiplies each block by the key matrix, and the
// letters leave one item per cycle while o_letter.ready is high.
//
//   channel   dir  handshake      payload
//   i_msg     in   valid/ready    msg_byte[7:0], msg_end
//   o_letter  out  valid/ready    cipher_letter[6:0], letter_last
//   i_cfg_*   in   write enable   i_cfg_idx[1:0], i_cfg_data[23:0]
//
// One byte is taken per cycle while i_msg.ready is high; a block's letters
// come out on consecutive cycles while o_letter.ready is high, after the block
// passes the three key-row cells and then the two mod-26 stages.
// Each stage holds its block when the next one is full, so i_msg.ready drops
// only when the whole row is backed up by o_letter.
// Synchronous reset clears the held-byte count and the valids and reloads the key rows.
// ============================================================================
`include "hill_cipher_3x3_mod26_top_assert.svh"

module hill_cipher_3x3_mod26_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hcm_in_if.sink                        i_msg,
    hcm_out_if.source                     o_letter,
    input  logic                          i_cfg_we,
    input  logic [hcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hcm_pkg::KEY_W-1:0]     i_cfg_data
);
    import hcm_pkg::*;

    logic [BLOCK_LEN-1:0][KEY_W-1:0]    r_key;
    logic [BLOCK_LEN-2:0][BYTE_W-1:0]   r_held;
    logic [CNT_W-1:0]                   r_count;
    logic [BLOCK_LEN-1:0][BYTE_W-1:0]   held_ext;
    logic                               launch;
    logic                               in_acc;
    t_blk                               blk_in;

    logic [BLOCK_LEN:0]                 s_valid;
    logic [BLOCK_LEN:0]                 s_ready;
    t_blk                               s_blk [BLOCK_LEN+1];

    assign launch        = (r_count == CNT_W'(BLOCK_LEN - 1)) || i_msg.msg_end;
    assign i_msg.ready   = s_ready[0];
    assign in_acc        = i_msg.valid && i_msg.ready;
    assign s_valid[0]    = i_msg.valid && launch;
    assign s_blk[0]      = blk_in;

    // block vector: held bytes, then this byte, zeros past the end
    always_comb begin
        held_ext       = KEY_W'(r_held);
        blk_in.sum     = '0;
        blk_in.present = r_count + CNT_W'(1);
        blk_in.last    = i_msg.msg_end;
        for (int k = 0; k < BLOCK_LEN; k++) begin
            if (CNT_W'(k) < r_count) begin
                blk_in.vec[k] = held_ext[k];
            end else if (CNT_W'(k) == r_count) begin
                blk_in.vec[k] = i_msg.msg_byte;
            end else begin
                blk_in.vec[k] = '0;
            end
        end
    end

    for (genvar k = 0; k < BLOCK_LEN; k++) begin : g_cell
        hcm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (s_valid[k]),
            .o_ready   (s_ready[k]),
            .i_blk     (s_blk[k]),
            .i_key_row (r_key[k]),
            .o_valid   (s_valid[k+1]),
            .i_ready   (s_ready[k+1]),
            .o_blk     (s_blk[k+1])
        );
    end

    hcm_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[BLOCK_LEN]),
        .o_ready  (s_ready[BLOCK_LEN]),
        .i_blk    (s_blk[BLOCK_LEN]),
        .o_letter (o_letter)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_ROW_ZERO: r_key[0] <= i_cfg_data;
                CFG_KEY_ROW_ONE:  r_key[1] <= i_cfg_data;
                CFG_KEY_ROW_TWO:  r_key[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= launch ? '0 : r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !launch) begin
            r_held[r_count[HELD_IDX_W-1:0]] <= i_msg.msg_byte;
        end
    end

    `HCM_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count < CNT_W'(BLOCK_LEN), "held count reached a full block")
    `HCM_ASSERT_IMPL(a_letter_range, i_clk, i_rst_n, o_letter.valid, (o_letter.cipher_letter >= LETTER_BASE) && (o_letter.cipher_letter <= LETTER_LAST), "letter outside A to Z")
    `HCM_ASSERT_NEXT(a_launch_enters, i_clk, i_rst_n, in_acc && launch, s_valid[1], "completed block did not enter the first cell")

endmodule

@@ verif/hcm_letter_checker.sv @@
// ----------------------------------------------------------------------------
// hcm_letter_checker
// Watches the byte and letter channels and the key write port of the Hill
// cipher, works out the cipher letters each accepted byte should produce and
// compares them in order against the letters that leave the block.
// ----------------------------------------------------------------------------
module hcm_letter_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hcm_in_if                             i_msg,
    hcm_out_if                            i_letter,
    input  logic                          i_cfg_we,
    input  logic [hcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hcm_pkg::KEY_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hcm_pkg::*;

    localparam int unsigned MOD_LETTERS = 26;
    localparam int unsigned ASCII_A     = 65;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_letter;

    t_letter                          letters_due[$];
    t_letter                          oldest;
    logic [BLOCK_LEN-1:0][KEY_W-1:0]  key_rows;
    logic [BLOCK_LEN-2:0][BYTE_W-1:0] held_bytes;
    int                               held_count;

    // letter of column col for block vec under the current key
    function automatic logic [LETTER_W-1:0] column_letter(
        input logic [BLOCK_LEN-1:0][BYTE_W-1:0] vec,
        input int                               col
    );
        int unsigned col_sum;
        col_sum = 0;
        for (int k = 0; k < BLOCK_LEN; k++) begin
            col_sum = col_sum + 32'(vec[k]) * 32'(key_rows[k][BYTE_W*col +: BYTE_W]);
        end
        return LETTER_W'(col_sum % MOD_LETTERS + ASCII_A);
    endfunction

    function automatic void gather_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        logic [BLOCK_LEN-1:0][BYTE_W-1:0] vec;
        int                               present;
        t_letter                          item;
        if (held_count < BLOCK_LEN - 1 && !msg_end) begin
            held_bytes[held_count] = b;
            held_count++;
            return;
        end
        // block complete; in a short final block missing bytes count as zero
        vec = '0;
        for (int k = 0; k < held_count; k++) begin
            vec[k] = held_bytes[k];
        end
        vec[held_count] = b;
        present = held_count + 1;
        for (int j = 0; j < present; j++) begin
            item.letter = column_letter(vec, j);
            item.last   = msg_end && (j == present - 1);
            letters_due.push_back(item);
        end
        held_bytes = '0;
        held_count = 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_rows     = {24'h6D6168, 24'h61686F, 24'h686F4D};
            held_bytes   = '0;
            held_count   = 0;
            o_fail_count = 0;
            letters_due.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx <= CFG_KEY_ROW_TWO) begin
                key_rows[i_cfg_idx] = i_cfg_data;
            end
            if (i_letter.valid && i_letter.ready) begin
                if (letters_due.size() == 0) begin
                    $display("%0t: unexpected letter: expected none, actual %0d last %0b",
                             $time, i_letter.cipher_letter, i_letter.letter_last);
                    o_fail_count++;
                end else begin
                    oldest = letters_due.pop_front();
                    if (i_letter.cipher_letter !== oldest.letter) begin
                        $display("%0t: cipher_letter mismatch: expected %0d, actual %0d",
                                 $time, oldest.letter, i_letter.cipher_letter);
                        o_fail_count++;
                    end
                    if (i_letter.letter_last !== oldest.last) begin
                        $display("%0t: letter_last mismatch: expected %0b, actual %0b",
                                 $time, oldest.last, i_letter.letter_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_msg.valid && i_msg.ready) begin
                gather_byte(i_msg.msg_byte, i_msg.msg_end);
            end
        end
        o_pending = letters_due.size();
    end

endmodule

@@ verif/tb_hill_cipher_3x3_mod26_top.sv @@
// ----------------------------------------------------------------------------
// tb_hill_cipher_3x3_mod26_top
// Drives messages of random length through the Hill cipher under several
// key settings, with random byte-side gaps and letter-side stalls (not in the
// last phase); the checker beside the block predicts every letter.
// ----------------------------------------------------------------------------
module tb_hill_cipher_3x3_mod26_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int                   STALL_LIMIT   = 2000;
    localparam int                   DRAIN_CYCLES  = 12;
    localparam int                   PHASE_ITEMS   = 44;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [KEY_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;
    int                   stall_left;
    bit                   idle_on;

    hcm_in_if  msg_ch();
    hcm_out_if letter_ch();

    hill_cipher_3x3_mod26_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_msg      (msg_ch),
        .o_letter   (letter_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hcm_letter_checker letter_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_msg        (msg_ch),
        .i_letter     (letter_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // letter side back-pressure in bursts
    initial begin
        letter_ch.ready = 1'b0;
        stall_left      = 0;
        forever begin
            @(negedge clk);
            if (idle_on && stall_left > 0) begin
                letter_ch.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                letter_ch.ready = 1'b0;
                stall_left      = $urandom_range(1, 16) - 1;
            end else begin
                letter_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (msg_ch.valid && msg_ch.ready) || (letter_ch.valid && letter_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("** hill_cipher_3x3_mod26_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key_row();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap          = $urandom_range(1, 16);
            msg_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid    = 1'b1;
        msg_ch.msg_byte = b;
        msg_ch.msg_end  = msg_end;
        do @(posedge clk); while (!msg_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_keys(input logic [KEY_W-1:0] row0, input logic [KEY_W-1:0] row1,
                             input logic [KEY_W-1:0] row2);
        write_key(CFG_KEY_ROW_ZERO, row0);
        write_key(CFG_KEY_ROW_ONE, row1);
        write_key(CFG_KEY_ROW_TWO, row2);
    endtask

    // every letter in, then let the cell row settle before touching keys
    task automatic wait_drained();
        msg_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int sent;
        int len;
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        msg_ch.valid    = 1'b0;
        msg_ch.msg_byte = '0;
        msg_ch.msg_end  = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_KEY_ROW_ZERO;
        cfg_data        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key: one-byte message, two-byte short block, full block
        send_byte(8'h00, 1'b0 | 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full block without end, then a one-byte tail
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_drained();

        load_keys('1, '1, '1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        wait_drained();

        // spare index must leave the key alone
        load_keys('0, '0, '0);
        write_key(CFG_IDX_SPARE, '1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            load_keys(pick_key_row(), pick_key_row(), pick_key_row());
            if ($urandom_range(0, 1) == 0) begin
                write_key(CFG_IDX_SPARE, pick_key_row());
            end
            if (phase == 3) begin
                idle_on = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    send_byte(pick_byte(), i == len - 1);
                end
                sent += len;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** hill_cipher_3x3_mod26_top: PASSED **");
        end else begin
            $display("** hill_cipher_3x3_mod26_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hcm_pkg.sv
rtl/hcm_in_if.sv
rtl/hcm_out_if.sv
rtl/hcm_cell.sv
rtl/hcm_emit.sv
rtl/hill_cipher_3x3_mod26_top.sv
verif/hcm_letter_checker.sv
verif/tb_hill_cipher_3x3_mod26_top.sv
